// ===== rtl/kswem_pkg.sv =====
// ----------------------------------------------------------------------------
// kswem_pkg
// Shared types and codes for the keyed stack with extract-min: request
// opcodes, result status codes, the search token that travels down the
// chain of cells and the command bundle that every cell receives.
// ----------------------------------------------------------------------------
package kswem_pkg;

  localparam int KeyW = 32;
  localparam int PayW = 32;

  typedef enum logic [2:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_PEEK      = 3'd2,
    OP_SEARCH    = 3'd3,
    OP_REMOVE    = 3'd4,
    OP_FINDMIN   = 3'd5,
    OP_REMOVEMIN = 3'd6
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Search token: the best entry seen so far on its way down the chain.
  typedef struct packed {
    logic                   active;
    logic                   found;
    logic signed [KeyW-1:0] key;
    logic [PayW-1:0]        payload;
  } scan_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic                   push;
    logic                   remove;
    logic                   mode_min;
    logic signed [KeyW-1:0] req_key;
  } cell_cmd_t;

endpackage

// ===== rtl/kswem_cell.sv =====
// ----------------------------------------------------------------------------
// kswem_cell
// One slot of the stack. It holds a key and a payload, shifts with its
// neighbours on push and removal, and updates the search token as it
// passes through.
// ----------------------------------------------------------------------------
module kswem_cell #(
  parameter int DEPTH = 16,
  parameter int IDX   = 0
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  kswem_pkg::cell_cmd_t                       cmd,
  input  logic [$clog2(DEPTH+1)-1:0]                 occ,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rm_pos,
  input  logic signed [kswem_pkg::KeyW-1:0]          prev_key,
  input  logic [kswem_pkg::PayW-1:0]                 prev_payload,
  input  logic signed [kswem_pkg::KeyW-1:0]          next_key,
  input  logic [kswem_pkg::PayW-1:0]                 next_payload,
  input  kswem_pkg::scan_t                           scan_in,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] pos_in,
  output logic signed [kswem_pkg::KeyW-1:0]          key,
  output logic [kswem_pkg::PayW-1:0]                 payload,
  output kswem_pkg::scan_t                           scan_out,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] pos_out
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                              in_use;
  logic                              hit;
  logic                              scan_active;
  logic                              scan_found;
  logic signed [kswem_pkg::KeyW-1:0] scan_key;
  logic [kswem_pkg::PayW-1:0]        scan_payload;

  assign in_use = (CW'(IDX) < occ);

  // A minimum search takes only a strictly smaller key, so ties stay with
  // the entry nearest the top; a key search takes the first match only.
  always_comb begin
    if (cmd.mode_min) begin
      hit = scan_in.active && in_use &&
            (!scan_in.found || ($signed(key) < $signed(scan_in.key)));
    end else begin
      hit = scan_in.active && in_use && !scan_in.found && (key == cmd.req_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
    end else begin
      scan_active <= scan_in.active;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      scan_found   <= 1'b1;
      scan_key     <= key;
      scan_payload <= payload;
      pos_out      <= PW'(IDX);
    end else begin
      scan_found   <= scan_in.found;
      scan_key     <= scan_in.key;
      scan_payload <= scan_in.payload;
      pos_out      <= pos_in;
    end
  end

  assign scan_out = '{active: scan_active, found: scan_found,
                      key: scan_key, payload: scan_payload};

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      key     <= prev_key;
      payload <= prev_payload;
    end else if (cmd.remove && (PW'(IDX) >= rm_pos)) begin
      key     <= next_key;
      payload <= next_payload;
    end
  end

endmodule

// ===== rtl/keyed_stack_with_extract_min.sv =====
// ----------------------------------------------------------------------------
// keyed_stack_with_extract_min
// A bounded stack of key and payload entries, newest first, with search and
// removal by key and search and removal of the minimum key.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals               Contents
//  s_axis    in         tvalid/tready/tdata   request: opcode, key, payload
//  m_axis    out        tvalid/tready/tdata   result: status, key, payload,
//                                              count, empty flag
//
// Push, pop, peek and unused opcodes finish at the edge at which the request
// is accepted; the result is shown in the following cycle.
// Search, remove, find-min and remove-min send a token down the row of
// cells, one cell per cycle; the start flag, every cell and the result
// register lie between acceptance and the result, so the chain length sets the wait.
// One request is worked on at a time: tready is low during a search and
// while an earlier result is waiting and not being taken in the same cycle.
// Reset is synchronous and clears the count, the control state and the
// output valid flag; the slot contents are not cleared, as only occupied
// slots are ever read.
// ----------------------------------------------------------------------------
module keyed_stack_with_extract_min #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: opcode[2:0], key[34:3], payload[66:35], zero pad.
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: status[1:0], entry_key[33:2], entry_payload[65:34],
  // count[70:66], is_empty[71].
  output logic [71:0] m_axis_tdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state;

  // Request fields.
  kswem_pkg::opcode_t                in_op;
  logic signed [kswem_pkg::KeyW-1:0] in_key;
  logic [kswem_pkg::PayW-1:0]        in_payload;

  // Held request for the search operations.
  kswem_pkg::opcode_t                req_op;
  logic signed [kswem_pkg::KeyW-1:0] req_key;
  logic                              start;

  logic [CW-1:0] occ;
  logic [CW-1:0] occ_next;

  logic in_acc;
  logic scan_op;
  logic take_req;
  logic push_go;
  logic pop_go;
  logic scan_rm;
  logic out_load;

  // Result register.
  logic                              out_valid;
  kswem_pkg::status_t                out_status;
  logic signed [kswem_pkg::KeyW-1:0] out_key;
  logic [kswem_pkg::PayW-1:0]        out_payload;
  logic [4:0]                        out_count;
  logic                              out_empty;

  // Result of the operations that finish at once.
  kswem_pkg::status_t                imm_status;
  logic signed [kswem_pkg::KeyW-1:0] imm_key;
  logic [kswem_pkg::PayW-1:0]        imm_payload;

  // Cell row.
  kswem_pkg::cell_cmd_t              cmd;
  logic [PW-1:0]                     rm_pos;
  logic signed [kswem_pkg::KeyW-1:0] cell_key     [DEPTH];
  logic [kswem_pkg::PayW-1:0]        cell_payload [DEPTH];
  kswem_pkg::scan_t                  scan         [DEPTH+1];
  logic [PW-1:0]                     pos          [DEPTH+1];

  assign in_op      = kswem_pkg::opcode_t'(s_axis_tdata[2:0]);
  assign in_key     = s_axis_tdata[34:3];
  assign in_payload = s_axis_tdata[66:35];

  assign s_axis_tready = (state == S_IDLE) && (!out_valid || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign scan_op = (in_op == kswem_pkg::OP_SEARCH) || (in_op == kswem_pkg::OP_REMOVE) ||
                   (in_op == kswem_pkg::OP_FINDMIN) || (in_op == kswem_pkg::OP_REMOVEMIN);
  assign take_req = (req_op == kswem_pkg::OP_REMOVE) || (req_op == kswem_pkg::OP_REMOVEMIN);

  // Pushes and pops act on the row at the edge of acceptance; a removal found
  // by a search acts at the edge at which the token leaves the last cell.
  assign push_go = in_acc && (in_op == kswem_pkg::OP_PUSH) && (occ < CW'(DEPTH));
  assign pop_go  = in_acc && (in_op == kswem_pkg::OP_POP) && (occ != '0);
  assign scan_rm = (state == S_SCAN) && scan[DEPTH].active && scan[DEPTH].found && take_req;

  // A result is loaded when a request that finishes at once is accepted, or
  // when the token leaves the last cell.
  assign out_load = ((state == S_IDLE) && in_acc && !scan_op) ||
                    ((state == S_SCAN) && scan[DEPTH].active);

  always_comb begin
    cmd.push     = push_go;
    cmd.remove   = pop_go || scan_rm;
    cmd.mode_min = (req_op == kswem_pkg::OP_FINDMIN) || (req_op == kswem_pkg::OP_REMOVEMIN);
    cmd.req_key  = req_key;
    rm_pos       = scan_rm ? pos[DEPTH] : '0;
  end

  always_comb begin
    if (cmd.push) begin
      occ_next = occ + CW'(1);
    end else if (cmd.remove) begin
      occ_next = occ - CW'(1);
    end else begin
      occ_next = occ;
    end
  end

  always_comb begin
    imm_status  = kswem_pkg::ST_NONE;
    imm_key     = '0;
    imm_payload = '0;
    unique case (in_op)
      kswem_pkg::OP_PUSH: begin
        imm_status = (occ < CW'(DEPTH)) ? kswem_pkg::ST_OK : kswem_pkg::ST_FULL;
      end
      kswem_pkg::OP_POP, kswem_pkg::OP_PEEK: begin
        if (occ != '0) begin
          imm_status  = kswem_pkg::ST_OK;
          imm_key     = cell_key[0];
          imm_payload = cell_payload[0];
        end
      end
      default: begin
        imm_status = kswem_pkg::ST_NONE;
      end
    endcase
  end

  // The token enters the top cell in the cycle after acceptance, once the
  // request key is held.
  assign scan[0] = '{active: start, found: 1'b0, key: '0, payload: '0};
  assign pos[0]  = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [kswem_pkg::KeyW-1:0] prev_key;
    logic [kswem_pkg::PayW-1:0]        prev_payload;
    logic signed [kswem_pkg::KeyW-1:0] next_key;
    logic [kswem_pkg::PayW-1:0]        next_payload;

    if (i == 0) begin : g_top
      assign prev_key     = in_key;
      assign prev_payload = in_payload;
    end else begin : g_mid
      assign prev_key     = cell_key[i-1];
      assign prev_payload = cell_payload[i-1];
    end

    // The bottom cell keeps its own contents on removal; that slot is then
    // beyond the count and is never read before a push fills it.
    if (i == DEPTH - 1) begin : g_bottom
      assign next_key     = cell_key[i];
      assign next_payload = cell_payload[i];
    end else begin : g_above
      assign next_key     = cell_key[i+1];
      assign next_payload = cell_payload[i+1];
    end

    kswem_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd),
      .occ          (occ),
      .rm_pos       (rm_pos),
      .prev_key     (prev_key),
      .prev_payload (prev_payload),
      .next_key     (next_key),
      .next_payload (next_payload),
      .scan_in      (scan[i]),
      .pos_in       (pos[i]),
      .key          (cell_key[i]),
      .payload      (cell_payload[i]),
      .scan_out     (scan[i+1]),
      .pos_out      (pos[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      start     <= 1'b0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      start <= (state == S_IDLE) && in_acc && scan_op;
      occ   <= occ_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            req_op  <= in_op;
            req_key <= in_key;
            if (scan_op) begin
              state <= S_SCAN;
            end else begin
              out_status  <= imm_status;
              out_key     <= imm_key;
              out_payload <= imm_payload;
              out_count   <= 5'(occ_next);
              out_empty   <= (occ_next == '0);
            end
          end
        end
        S_SCAN: begin
          if (scan[DEPTH].active) begin
            state       <= S_IDLE;
            out_status  <= scan[DEPTH].found ? kswem_pkg::ST_OK : kswem_pkg::ST_NONE;
            out_key     <= scan[DEPTH].found ? scan[DEPTH].key : '0;
            out_payload <= scan[DEPTH].found ? scan[DEPTH].payload : '0;
            out_count   <= 5'(occ_next);
            out_empty   <= (occ_next == '0);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_empty, out_count, out_payload, out_key, out_status};

`ifndef ASSERT_OFF
  // The token may only leave the chain while a search is in progress.
  a_token_in_scan : assert property (@(posedge clk) disable iff (rst)
    scan[DEPTH].active |-> (state == S_SCAN))
    else $error("search token left the chain outside a search");

  // The count never exceeds the number of cells.
  a_occ_bound : assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(DEPTH))
    else $error("occupancy above depth");

  // A removal found by a search takes exactly one entry away.
  a_scan_remove : assert property (@(posedge clk) disable iff (rst)
    scan_rm |=> (occ == $past(occ) - CW'(1)))
    else $error("search removal did not decrement occupancy");

  // No result is pending while a search is running.
  a_scan_no_out : assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !out_valid)
    else $error("result pending during a search");
`endif

endmodule
